// File: rtl/core/rtsk_pkg.sv
// ----------------------------------------------------------------------------
// rtsk_pkg: shared types and constants of the RTOS task and semaphore kernel.
// Holds the task modes, event kinds, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package rtsk_pkg;

  localparam int unsigned Tasks      = 12;
  localparam int unsigned Semaphores = 5;
  localparam int unsigned QueueDepth = 5;
  localparam int unsigned TaskW      = 4;
  localparam int unsigned SemW       = 3;
  localparam int unsigned CntW       = 3;
  localparam int unsigned FifoDepth  = Semaphores * QueueDepth;
  localparam int unsigned FifoAw     = 5;

  typedef enum logic [2:0] {
    ModeInvalid = 3'd0,
    ModeUnrun   = 3'd1,
    ModeReady   = 3'd2,
    ModeDelayed = 3'd3,
    ModeBlocked = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KindYield = 3'd0,
    KindSleep = 3'd1,
    KindWait  = 3'd2,
    KindPost  = 3'd3,
    KindTick  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSem  = 2'd1,
    StFull    = 2'd2,
    StNoReady = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SEval,
    SShift,
    STick,
    SPick,
    SOut
  } state_e;

  typedef enum logic [2:0] {
    CfgMask = 3'd0,
    CfgSem0 = 3'd1
  } cfg_e;

endpackage

// File: rtl/core/rtos_task_semaphore_kernel_top.sv
// ----------------------------------------------------------------------------
// rtos_task_semaphore_kernel_top: hardware round-robin RTOS kernel.
// The s_axis channel takes one kernel event per beat: tdata holds sleep_ticks
// in bits 31:0 and sem_index in bits 34:32, tuser holds the event kind.
// The m_axis channel returns one result beat per event. A separate write
// channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) loads the task
// valid mask (index 0) and the semaphore counts (indices 1 to 5); it is only
// written while no event is in flight.
// An event passes from idle through evaluation and the pick state to the output
// beat. When a switch is needed the scheduler scans up to all twelve tasks one per
// cycle, and a tick first sweeps the task table one task per cycle through a
// single shared decrement and compare unit. A post that releases a task first
// shifts its wait queue, which holds up to five waiters, one entry per cycle.
// After reset all tasks are invalid, all counts are zero and the first scan
// starts at task zero. The block takes no new event until the result beat
// has been taken; a stalled receiver simply holds the kernel.
// ----------------------------------------------------------------------------
module rtos_task_semaphore_kernel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sleep_ticks[31:0], sem_index[34:32]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // switched, running_task[4:1], fresh_start,
                                      // woken_valid, woken_task[10:7], status[12:11]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import rtsk_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q [Tasks];
  logic [31:0] sleep_q [Tasks];
  logic [15:0] level_q [Semaphores];
  logic [CntW-1:0] wait_q [Semaphores];
  logic [TaskW-1:0] fifo_q [FifoDepth];
  logic [TaskW-1:0] run_q, scan_q, woken_q;
  logic [2:0] kind_q;
  logic [31:0] ticks_q;
  logic [SemW-1:0] sem_q;
  logic sw_q, fresh_q, wv_q, do_sw_q;
  logic [1:0] st_q;
  logic [CntW-1:0] sh_q;
  logic [TaskW-1:0] step_q;

  logic [FifoAw-1:0] base;
  logic sem_ok;
  logic [TaskW-1:0] nxt;

  assign sem_ok = {1'b0, sem_q} < 4'(Semaphores);
  assign base   = 5'(sem_q) * 5'(QueueDepth);
  assign nxt    = (scan_q == 4'(Tasks - 1)) ? '0 : scan_q + 4'd1;

  assign s_axis_tready = state_q == SIdle;
  assign cfg_ready_o   = state_q == SIdle;
  assign m_axis_tvalid = state_q == SOut;
  assign m_axis_tdata  = {3'b0, st_q, woken_q, wv_q, fresh_q, run_q, sw_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:  if (s_axis_tvalid) state_d = SEval;
      SEval: begin
        if (kind_q == KindTick) state_d = STick;
        else if (kind_q == KindPost && sem_ok && wait_q[sem_q] > 0) state_d = SShift;
        else state_d = SPick;
      end
      SShift: if (sh_q + 3'd1 >= wait_q[sem_q]) state_d = SPick;
      STick:  if (step_q == 4'(Tasks - 1)) state_d = SPick;
      SPick: begin
        if (!do_sw_q) state_d = SOut;
        else if (mode_q[nxt] == ModeReady || mode_q[nxt] == ModeUnrun) state_d = SOut;
        else if (step_q == 4'(Tasks - 1)) state_d = SOut;
      end
      SOut:   if (m_axis_tready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      run_q   <= 4'(Tasks - 1);
      for (int i = 0; i < Tasks; i++) begin
        mode_q[i]  <= ModeInvalid;
        sleep_q[i] <= '0;
      end
      for (int i = 0; i < Semaphores; i++) begin
        level_q[i] <= '0;
        wait_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        SIdle: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == CfgMask) begin
              for (int i = 0; i < Tasks; i++) begin
                mode_q[i]  <= cfg_data_i[i] ? ModeUnrun : ModeInvalid;
                sleep_q[i] <= '0;
              end
            end else if (cfg_index_i >= CfgSem0 && cfg_index_i <= 3'(Semaphores)) begin
              level_q[cfg_index_i - 3'd1] <= cfg_data_i;
              wait_q[cfg_index_i - 3'd1]  <= '0;
            end
          end
        end
        SEval: begin
          case (kind_q)
            KindYield: do_sw_q <= 1'b1;
            KindSleep: begin
              if (mode_q[run_q] == ModeReady) begin
                sleep_q[run_q] <= ticks_q;
                mode_q[run_q]  <= ModeDelayed;
              end
              do_sw_q <= 1'b1;
            end
            KindWait: begin
              if (!sem_ok) st_q <= StBadSem;
              else if (level_q[sem_q] > 0) level_q[sem_q] <= level_q[sem_q] - 16'd1;
              else if (wait_q[sem_q] >= 3'(QueueDepth)) st_q <= StFull;
              else begin
                if (mode_q[run_q] == ModeReady) begin
                  fifo_q[base + 5'(wait_q[sem_q])] <= run_q;
                  wait_q[sem_q] <= wait_q[sem_q] + 3'd1;
                  mode_q[run_q] <= ModeBlocked;
                end
                do_sw_q <= 1'b1;
              end
            end
            KindPost: begin
              if (!sem_ok) st_q <= StBadSem;
              else if (wait_q[sem_q] > 0) begin
                woken_q <= fifo_q[base];
                wv_q    <= 1'b1;
              end else if (level_q[sem_q] != 16'hFFFF) begin
                level_q[sem_q] <= level_q[sem_q] + 16'd1;
              end
            end
            default: ;
          endcase
        end
        SShift: begin
          if (sh_q + 3'd1 < wait_q[sem_q]) begin
            fifo_q[base + 5'(sh_q)] <= fifo_q[base + 5'(sh_q) + 5'd1];
            sh_q <= sh_q + 3'd1;
          end else begin
            wait_q[sem_q] <= wait_q[sem_q] - 3'd1;
            if (mode_q[woken_q] == ModeBlocked) mode_q[woken_q] <= ModeReady;
          end
        end
        STick: begin
          if (mode_q[step_q] == ModeDelayed) begin
            if (sleep_q[step_q] == '0) mode_q[step_q] <= ModeReady;
            else sleep_q[step_q] <= sleep_q[step_q] - 32'd1;
          end
          step_q <= (step_q == 4'(Tasks - 1)) ? '0 : step_q + 4'd1;
        end
        SPick: begin
          if (do_sw_q) begin
            scan_q <= nxt;
            step_q <= step_q + 4'd1;
            if (mode_q[nxt] == ModeReady || mode_q[nxt] == ModeUnrun) begin
              sw_q    <= 1'b1;
              fresh_q <= mode_q[nxt] == ModeUnrun;
              mode_q[nxt] <= ModeReady;
              run_q   <= nxt;
            end else if (step_q == 4'(Tasks - 1)) begin
              st_q <= StNoReady;
            end
          end
        end
        default: ;
      endcase
      if (state_q == SIdle && s_axis_tvalid) begin
        kind_q  <= s_axis_tuser;
        ticks_q <= s_axis_tdata[31:0];
        sem_q   <= s_axis_tdata[34:32];
        sw_q    <= 1'b0;
        fresh_q <= 1'b0;
        wv_q    <= 1'b0;
        woken_q <= '0;
        st_q    <= StOk;
        do_sw_q <= 1'b0;
        sh_q    <= '0;
        step_q  <= '0;
        scan_q  <= run_q;
      end
    end
  end

endmodule
